### hdl/bac_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the edge test for the blocking artifact counter.
// No dependencies.
package bac_pkg;

   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);

   localparam int PIXEL_W    = 8;
   localparam int THR_W      = 8;
   localparam int SIZE_W     = 13;
   localparam int COUNT_W    = 25;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   // first column / row with a full four-pixel neighborhood behind it
   localparam int EDGE_START = 3;

   localparam logic [THR_W-1:0]  THR_RESET    = THR_W'(30);
   localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
   localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_THRESHOLD = 2'd0,
      REG_WIDTH     = 2'd1,
      REG_HEIGHT    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [THR_W-1:0] thr;
      logic [COL_W-1:0] col_last;
      logic [ROW_W-1:0] row_last;
      logic             restart;
   } cfg_type;

   typedef struct packed {
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic             last_col;
      logic             last_row;
   } pos_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] prior;
      logic [PIXEL_W-1:0] second;
      logic [PIXEL_W-1:0] third;
   } row_word_type;

   function automatic logic [PIXEL_W-1:0] sat_sub(input logic [PIXEL_W-1:0] x,
                                                  input logic [PIXEL_W-1:0] y);
      return (x > y) ? PIXEL_W'(x - y) : '0;
   endfunction

   // p: center, n: next, b1: one before, b2: two before
   function automatic logic edge_test(input logic [PIXEL_W-1:0] p,
                                      input logic [PIXEL_W-1:0] n,
                                      input logic [PIXEL_W-1:0] b1,
                                      input logic [PIXEL_W-1:0] b2,
                                      input logic [THR_W-1:0]   thr);
      logic [PIXEL_W-1:0] d;
      logic [PIXEL_W-1:0] a;
      logic [PIXEL_W-1:0] b;
      d = sat_sub(p, n);
      a = sat_sub(d, sat_sub(b1, p));
      b = sat_sub(d, sat_sub(n, b2));
      return (a > thr) && (b > thr);
   endfunction

   function automatic logic [COL_W-1:0] width_last(input logic [SIZE_W-1:0] v);
      if (v == '0) begin
         return '0;
      end else if (int'(v) > MAX_WIDTH) begin
         return COL_W'(MAX_WIDTH - 1);
      end else begin
         return COL_W'(v - SIZE_W'(1));
      end
   endfunction

   function automatic logic [ROW_W-1:0] height_last(input logic [SIZE_W-1:0] v);
      if (v == '0) begin
         return '0;
      end else if (int'(v) > MAX_HEIGHT) begin
         return ROW_W'(MAX_HEIGHT - 1);
      end else begin
         return ROW_W'(v - SIZE_W'(1));
      end
   endfunction

endpackage

### hdl/bac_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: pixel input, result output, register writes.
// Depends on bac_pkg.
interface bac_req_if;
   logic                        valid;
   logic                        ready;
   logic [bac_pkg::PIXEL_W-1:0] pixel;
   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

interface bac_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [bac_pkg::COUNT_W-1:0] flagged_count;
   logic [bac_pkg::COUNT_W-1:0] pixel_total;
   modport source (output valid, output flagged_count, output pixel_total, input ready);
   modport sink   (input valid, input flagged_count, input pixel_total, output ready);
endinterface

interface bac_csr_if;
   logic                           valid;
   logic                           ready;
   logic [bac_pkg::CSR_IDX_W-1:0]  index;
   logic [bac_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/bac_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module bac_ram #(
   parameter int DATA_W = 8,
   parameter int ADDR_W = 12
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/bac_scan.sv
`timescale 1ns / 1ps
// Configuration registers and raster position counters.
// Depends on bac_pkg and bac_if.
module bac_scan (
   input  logic              clock,
   input  logic              reset,
   bac_csr_if.sink           csr_chan,
   input  logic              advance,
   output bac_pkg::cfg_type  cfg,
   output bac_pkg::pos_type  pos
);

   logic [bac_pkg::THR_W-1:0]  thr_ff;
   logic [bac_pkg::SIZE_W-1:0] width_ff;
   logic [bac_pkg::SIZE_W-1:0] height_ff;
   logic [bac_pkg::COL_W-1:0]  col_ff, col_in;
   logic [bac_pkg::ROW_W-1:0]  row_ff, row_in;
   logic                       csr_wr;
   logic                       restart;

   assign csr_chan.ready = 1'b1;
   assign csr_wr  = csr_chan.valid && csr_chan.ready;
   assign restart = csr_wr && (csr_chan.index inside {bac_pkg::REG_WIDTH, bac_pkg::REG_HEIGHT});

   assign cfg.thr      = thr_ff;
   assign cfg.col_last = bac_pkg::width_last(width_ff);
   assign cfg.row_last = bac_pkg::height_last(height_ff);
   assign cfg.restart  = restart;

   assign pos.col      = col_ff;
   assign pos.row      = row_ff;
   assign pos.last_col = (col_ff == cfg.col_last);
   assign pos.last_row = (row_ff == cfg.row_last);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (advance) begin
         if (pos.last_col) begin
            col_in = '0;
            row_in = pos.last_row ? '0 : bac_pkg::ROW_W'(row_ff + 1'b1);
         end else begin
            col_in = bac_pkg::COL_W'(col_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= bac_pkg::THR_RESET;
         width_ff  <= bac_pkg::WIDTH_RESET;
         height_ff <= bac_pkg::HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (csr_wr) begin
            case (csr_chan.index)
               bac_pkg::REG_THRESHOLD: thr_ff    <= csr_chan.data[bac_pkg::THR_W-1:0];
               bac_pkg::REG_WIDTH:     width_ff  <= csr_chan.data;
               bac_pkg::REG_HEIGHT:    height_ff <= csr_chan.data;
               default: ;
            endcase
         end
      end
   end

endmodule

### hdl/blocking_artifact_counter_core.sv
`timescale 1ns / 1ps
// Blocking artifact counter top level: line-buffer RAMs, edge scoring, tally, result register.
// Depends on bac_pkg, bac_if, bac_ram and bac_scan.

// Takes one pixel per clock in raster order. Each accepted pixel reads its column of
// the three-row line buffer and the previous row's flag RAM, and in the next cycle is
// scored and written back; same-column reuse by back-to-back pixels is forwarded. The
// frame result is registered after its last pixel has been scored. Input stalls only
// on the last pixel of a frame while the previous result is still held, or between
// back-to-back 1x1 frames. No clearing pass after reset.
module blocking_artifact_counter_core (
   input  logic      clock,
   input  logic      reset,
   bac_req_if.sink   req_chan,
   bac_rsp_if.source rsp_chan,
   bac_csr_if.sink   csr_chan
);

   localparam int ROW_DATA_W = $bits(bac_pkg::row_word_type);

   bac_pkg::cfg_type cfg;
   bac_pkg::pos_type pos;
   logic             accept;

   bac_pkg::pos_type              s1_pos_ff;
   logic                          s1_valid_ff;
   logic [bac_pkg::PIXEL_W-1:0]   s1_pix_ff;
   logic [bac_pkg::PIXEL_W-1:0]   win_ff [3];
   logic [bac_pkg::COUNT_W-1:0]   tally_ff, tally_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [bac_pkg::COUNT_W-1:0]   flagged_ff;
   logic [bac_pkg::COUNT_W-1:0]   total_ff;
   logic                          fwd_row_ff, fwd_flag_ff;
   bac_pkg::row_word_type         fwd_row_data_ff;
   logic                          fwd_flag_data_ff;

   bac_pkg::row_word_type         row_rd, row_cur, row_wr;
   logic [ROW_DATA_W-1:0]         row_rd_bits;
   logic                          flag_rd, flag_cur;
   logic                          flag_we;
   logic [bac_pkg::COL_W-1:0]     flag_waddr;
   logic                          rf, cf, inc_a, inc_b, s1_last, stall;
   logic [bac_pkg::COUNT_W-1:0]   tally_sum;
   logic [bac_pkg::COL_W:0]       w_size;
   logic [bac_pkg::ROW_W:0]       h_size;

   bac_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .advance  (accept),
      .cfg      (cfg),
      .pos      (pos)
   );

   assign s1_last = s1_valid_ff && s1_pos_ff.last_col && s1_pos_ff.last_row;
   assign stall   = pos.last_col && pos.last_row
                    && ((rsp_valid_ff && !rsp_chan.ready) || s1_last);
   assign req_chan.ready = !stall;
   assign accept = req_chan.valid && req_chan.ready;

   bac_ram #(.DATA_W(ROW_DATA_W), .ADDR_W(bac_pkg::COL_W)) u_row_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_pos_ff.col),
      .wr_data (row_wr),
      .rd_en   (accept),
      .rd_addr (pos.col),
      .rd_data (row_rd_bits)
   );

   bac_ram #(.DATA_W(1), .ADDR_W(bac_pkg::COL_W)) u_flag_ram (
      .clock   (clock),
      .wr_en   (flag_we),
      .wr_addr (flag_waddr),
      .wr_data (rf),
      .rd_en   (accept),
      .rd_addr (pos.col),
      .rd_data (flag_rd)
   );

   assign row_rd = bac_pkg::row_word_type'(row_rd_bits);

   always_comb begin
      row_cur  = fwd_row_ff  ? fwd_row_data_ff  : row_rd;
      flag_cur = fwd_flag_ff ? fwd_flag_data_ff : flag_rd;
      if (s1_pos_ff.last_col) begin
         flag_cur = 1'b0;
      end

      rf = (s1_pos_ff.col >= bac_pkg::COL_W'(bac_pkg::EDGE_START))
           && bac_pkg::edge_test(win_ff[0], s1_pix_ff, win_ff[1], win_ff[2], cfg.thr);
      cf = (s1_pos_ff.row >= bac_pkg::ROW_W'(bac_pkg::EDGE_START))
           && bac_pkg::edge_test(row_cur.prior, s1_pix_ff, row_cur.second,
                                 row_cur.third, cfg.thr);

      inc_a = (s1_pos_ff.row != '0) && (flag_cur || cf);
      inc_b = s1_pos_ff.last_row && (s1_pos_ff.col != '0) && rf;

      row_wr.prior  = s1_pix_ff;
      row_wr.second = row_cur.prior;
      row_wr.third  = row_cur.second;

      flag_we    = s1_valid_ff && !s1_pos_ff.last_row && (s1_pos_ff.col != '0);
      flag_waddr = bac_pkg::COL_W'(s1_pos_ff.col - 1'b1);

      tally_sum = bac_pkg::COUNT_W'(tally_ff + bac_pkg::COUNT_W'(inc_a)
                                    + bac_pkg::COUNT_W'(inc_b));
      tally_in  = tally_ff;
      if (cfg.restart) begin
         tally_in = '0;
      end else if (s1_valid_ff) begin
         tally_in = s1_last ? '0 : tally_sum;
      end

      rsp_valid_in = rsp_valid_ff;
      if (s1_last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      w_size = (bac_pkg::COL_W + 1)'(cfg.col_last) + 1'b1;
      h_size = (bac_pkg::ROW_W + 1)'(cfg.row_last) + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         tally_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         fwd_row_ff   <= 1'b0;
         fwd_flag_ff  <= 1'b0;
      end else begin
         s1_valid_ff  <= accept;
         tally_ff     <= tally_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            fwd_row_ff  <= s1_valid_ff && (s1_pos_ff.col == pos.col);
            fwd_flag_ff <= flag_we && (flag_waddr == pos.col);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pos_ff        <= pos;
         s1_pix_ff        <= req_chan.pixel;
         fwd_row_data_ff  <= row_wr;
         fwd_flag_data_ff <= rf;
      end
      if (s1_valid_ff) begin
         win_ff[2] <= win_ff[1];
         win_ff[1] <= win_ff[0];
         win_ff[0] <= s1_pix_ff;
      end
      if (s1_last) begin
         flagged_ff <= tally_sum;
         total_ff   <= bac_pkg::COUNT_W'(w_size) * bac_pkg::COUNT_W'(h_size);
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.flagged_count = flagged_ff;
   assign rsp_chan.pixel_total   = total_ff;

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for blocking_artifact_counter_core: random pixel frames, register
// writes and handshake stalls, with an in-bench frame tally predictor checked per result.
// Depends on bac_pkg, bac_if and the core RTL.
module tb_top;
   import bac_pkg::*;

   localparam int          IDLE_MAX     = 6;
   localparam int          LONG_HOLD    = 80;
   localparam int          DRAIN_CYCLES = 8;
   localparam int          RUN_LIMIT    = 100_000;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 2'd3;

   typedef enum int {TEXTURE_NOISE, TEXTURE_BLOCKS, TEXTURE_RAILS} texture_type;

   typedef struct packed {
      logic [COUNT_W-1:0] flagged;
      logic [COUNT_W-1:0] total;
   } frame_result_type;

   logic clock;
   logic reset;

   bac_req_if req_if ();
   bac_rsp_if rsp_if ();
   bac_csr_if csr_if ();

   blocking_artifact_counter_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // predictor state
   logic [THR_W-1:0]   thr_reg;
   logic [SIZE_W-1:0]  width_reg;
   logic [SIZE_W-1:0]  height_reg;
   logic [PIXEL_W-1:0] row_m1 [MAX_WIDTH];
   logic [PIXEL_W-1:0] row_m2 [MAX_WIDTH];
   logic [PIXEL_W-1:0] row_m3 [MAX_WIDTH];
   bit                 row_edge [MAX_WIDTH];
   logic [PIXEL_W-1:0] tail [3];
   int                 col_pos;
   int                 row_pos;
   int                 tally;

   frame_result_type   frame_results [$];
   logic [PIXEL_W-1:0] pixel_queue [$];

   int          pixels_queued;
   int          pixels_accepted;
   int          results_seen;
   int          reg_writes;
   int          input_stalls;
   int          errors;
   int          cycle_count;
   int unsigned gap_max;
   int unsigned stall_max;
   int unsigned gap_left;
   int unsigned stall_left;
   int unsigned hold_count;
   bit          hold_request;
   bit          req_beat;
   bit          rsp_beat;
   bit          csr_beat;
   texture_type texture;
   int          run_level;
   int          run_left;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic int fit_size(input logic [SIZE_W-1:0] v, input int maxv);
      if (v == '0) begin
         return 1;
      end
      return (int'(v) > maxv) ? maxv : int'(v);
   endfunction

   function automatic bit is_edge(input int ctr, input int nxt, input int pre1,
                                  input int pre2, input int thr);
      int drop;
      int lift_in;
      int lift_out;
      int a;
      int b;
      drop     = (ctr > nxt) ? ctr - nxt : 0;
      lift_in  = (pre1 > ctr) ? pre1 - ctr : 0;
      lift_out = (nxt > pre2) ? nxt - pre2 : 0;
      a = (drop > lift_in) ? drop - lift_in : 0;
      b = (drop > lift_out) ? drop - lift_out : 0;
      return (a > thr) && (b > thr);
   endfunction

   task automatic restart_frame();
      col_pos = 0;
      row_pos = 0;
      tally   = 0;
   endtask

   task automatic apply_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      case (csr_index_type'(idx))
         REG_THRESHOLD: thr_reg = data[THR_W-1:0];
         REG_WIDTH: begin
            width_reg = data;
            restart_frame();
         end
         REG_HEIGHT: begin
            height_reg = data;
            restart_frame();
         end
         default: ;
      endcase
   endtask

   // one pixel into the frame tally; a finished frame queues its result
   task automatic count_pixel(input logic [PIXEL_W-1:0] px);
      int               w;
      int               h;
      int               c;
      int               r;
      bit               rf;
      bit               cf;
      frame_result_type res;
      w  = fit_size(width_reg, MAX_WIDTH);
      h  = fit_size(height_reg, MAX_HEIGHT);
      c  = col_pos;
      r  = row_pos;
      rf = 1'b0;
      cf = 1'b0;
      if (c >= 3) begin
         rf = is_edge(tail[0], px, tail[1], tail[2], thr_reg);
      end
      if (r >= 1) begin
         if (r >= 3) begin
            cf = is_edge(row_m1[c], px, row_m2[c], row_m3[c], thr_reg);
         end
         if (row_edge[c] || cf) begin
            tally++;
         end
      end
      if (r == h - 1) begin
         if (c >= 1 && rf) begin
            tally++;
         end
      end else begin
         if (c >= 1) begin
            row_edge[c-1] = rf;
         end
         if (c == w - 1) begin
            row_edge[c] = 1'b0;
         end
      end
      row_m3[c] = row_m2[c];
      row_m2[c] = row_m1[c];
      row_m1[c] = px;
      tail[2] = tail[1];
      tail[1] = tail[0];
      tail[0] = px;
      if (c + 1 >= w) begin
         col_pos = 0;
         if (r + 1 >= h) begin
            res.flagged = COUNT_W'(tally);
            res.total   = COUNT_W'(w * h);
            frame_results.push_back(res);
            restart_frame();
         end else begin
            row_pos = r + 1;
         end
      end else begin
         col_pos = c + 1;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [COUNT_W-1:0] got,
                                  input logic [COUNT_W-1:0] want);
      $display("mismatch at %0t ns: %s got %0d want %0d", $time, what, got, want);
      errors++;
   endtask

   function automatic logic [PIXEL_W-1:0] draw_pixel();
      int v;
      case (texture)
         TEXTURE_NOISE: v = $urandom_range(0, 255);
         TEXTURE_BLOCKS: begin
            if (run_left == 0) begin
               run_level = $urandom_range(0, 255);
               run_left  = $urandom_range(1, 4);
            end
            run_left--;
            v = run_level + int'($urandom_range(0, 6)) - 3;
            v = (v < 0) ? 0 : ((v > 255) ? 255 : v);
         end
         default: begin
            case ($urandom_range(0, 2))
               0: v = 0;
               1: v = 255;
               default: v = $urandom_range(0, 255);
            endcase
         end
      endcase
      return PIXEL_W'(v);
   endfunction

   // timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   // input side: beat detection and prediction
   always @(posedge clock) begin
      req_beat <= !reset && req_if.valid && req_if.ready;
      if (!reset && req_if.valid && req_if.ready) begin
         count_pixel(req_if.pixel);
         pixels_accepted <= pixels_accepted + 1;
      end
      if (!reset && req_if.valid && !req_if.ready) begin
         input_stalls <= input_stalls + 1;
      end
   end

   always @(posedge clock) begin
      csr_beat <= !reset && csr_if.valid && csr_if.ready;
      if (!reset && csr_if.valid && csr_if.ready) begin
         apply_reg(csr_if.index, csr_if.data);
      end
   end

   always @(posedge clock) begin : rsp_check
      frame_result_type want;
      rsp_beat <= !reset && rsp_if.valid && rsp_if.ready;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (frame_results.size() == 0) begin
            report_mismatch("result beat with no frame pending", rsp_if.flagged_count, '0);
         end else begin
            want = frame_results.pop_front();
            if (rsp_if.flagged_count !== want.flagged) begin
               report_mismatch("flagged_count", rsp_if.flagged_count, want.flagged);
            end
            if (rsp_if.pixel_total !== want.total) begin
               report_mismatch("pixel_total", rsp_if.pixel_total, want.total);
            end
         end
         results_seen <= results_seen + 1;
      end
   end

   always @(posedge clock) begin
      if (!hold_request) begin
         hold_count <= 0;
      end else if (hold_count != LONG_HOLD) begin
         hold_count <= hold_count + 1;
      end
   end

   // pixel driver
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         gap_left     <= 0;
      end else if (!req_if.valid || req_beat) begin
         if (gap_left != 0) begin
            req_if.valid <= 1'b0;
            gap_left     <= gap_left - 1;
         end else if (pixel_queue.size() != 0) begin
            req_if.pixel <= pixel_queue.pop_front();
            req_if.valid <= 1'b1;
            gap_left     <= $urandom_range(0, gap_max);
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // result receiver
   always @(negedge clock) begin : rsp_drive
      int unsigned wait_n;
      logic        held;
      held = hold_request && (hold_count != LONG_HOLD);
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= 0;
      end else if (rsp_beat) begin
         wait_n = $urandom_range(0, stall_max);
         stall_left   <= wait_n;
         rsp_if.ready <= (wait_n == 0) && !held;
      end else if (stall_left != 0) begin
         stall_left   <= stall_left - 1;
         rsp_if.ready <= (stall_left == 1) && !held;
      end else begin
         rsp_if.ready <= !held;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      do @(negedge clock); while (!csr_beat);
      csr_if.valid <= 1'b0;
      reg_writes++;
   endtask

   task automatic push_pixel(input logic [PIXEL_W-1:0] px);
      pixel_queue.push_back(px);
      pixels_queued++;
   endtask

   task automatic push_texture(input int n);
      repeat (n) push_pixel(draw_pixel());
   endtask

   task automatic settle();
      while (pixels_accepted != pixels_queued || frame_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic shuffle_idling();
      gap_max   = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
      stall_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
      case ($urandom_range(0, 3))
         0: texture = TEXTURE_NOISE;
         1: texture = TEXTURE_RAILS;
         default: texture = TEXTURE_BLOCKS;
      endcase
   endtask

   function automatic logic [SIZE_W-1:0] pick_size();
      int r;
      r = $urandom_range(0, 19);
      if (r < 4) begin
         return SIZE_W'(r);
      end else if (r < 18) begin
         return SIZE_W'($urandom_range(4, 8));
      end
      return SIZE_W'($urandom_range(9, 12));
   endfunction

   function automatic logic [THR_W-1:0] pick_threshold();
      case ($urandom_range(0, 6))
         0: return '0;
         1: return '1;
         2: return THR_W'($urandom_range(0, 255));
         default: return THR_W'($urandom_range(1, 40));
      endcase
   endfunction

   initial begin
      logic [PIXEL_W-1:0] step_row [5];
      logic [PIXEL_W-1:0] rail_tile [16];
      int                 area;
      int                 frames;
      int                 extra;
      int                 rnd_pixels;

      step_row  = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd0};
      rail_tile = '{8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0,
                    8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255};

      reset        = 1'b1;
      csr_if.valid = 1'b0;
      csr_if.index = '0;
      csr_if.data  = '0;
      hold_request = 1'b0;
      gap_max      = IDLE_MAX;
      stall_max    = IDLE_MAX;
      texture      = TEXTURE_BLOCKS;
      run_left     = 0;
      run_level    = 0;
      thr_reg      = THR_RESET;
      width_reg    = WIDTH_RESET;
      height_reg   = HEIGHT_RESET;
      for (int i = 0; i < MAX_WIDTH; i++) begin
         row_m1[i]   = '0;
         row_m2[i]   = '0;
         row_m3[i]   = '0;
         row_edge[i] = 1'b0;
      end
      tail = '{default: '0};
      restart_frame();

      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // reset sizes: a partial frame dropped by the next size write,
      // then a small frame at the reset threshold
      push_texture(80);
      settle();
      write_reg(REG_WIDTH, 13'd6);
      write_reg(REG_HEIGHT, 13'd5);
      push_texture(30);
      settle();

      // directed shapes at the pixel extremes
      write_reg(REG_SPARE, 13'h1ABC);
      write_reg(REG_THRESHOLD, 13'h1F00);
      write_reg(REG_WIDTH, 13'd5);
      write_reg(REG_HEIGHT, 13'd1);
      foreach (step_row[i]) push_pixel(step_row[i]);
      settle();
      write_reg(REG_WIDTH, 13'd1);
      write_reg(REG_HEIGHT, 13'd5);
      foreach (step_row[i]) push_pixel(step_row[i]);
      settle();
      write_reg(REG_THRESHOLD, 13'd254);
      write_reg(REG_WIDTH, 13'd4);
      write_reg(REG_HEIGHT, 13'd4);
      foreach (rail_tile[i]) push_pixel(rail_tile[i]);
      settle();

      // largest and clamped sizes, partial frames
      shuffle_idling();
      write_reg(REG_THRESHOLD, 13'd12);
      write_reg(REG_WIDTH, 13'd8191);
      write_reg(REG_HEIGHT, 13'd1);
      push_texture(24);
      settle();
      shuffle_idling();
      write_reg(REG_WIDTH, SIZE_W'(MAX_WIDTH));
      write_reg(REG_HEIGHT, 13'd4);
      push_texture(24);
      settle();
      shuffle_idling();
      write_reg(REG_WIDTH, 13'd1);
      write_reg(REG_HEIGHT, 13'd8191);
      push_texture(24);
      settle();

      // back-pressure: 1x1 frames while the receiver holds off
      gap_max   = 0;
      stall_max = 0;
      write_reg(REG_WIDTH, 13'd0);
      write_reg(REG_HEIGHT, 13'd0);
      hold_request = 1'b1;
      push_texture(40);
      settle();
      hold_request = 1'b0;

      // random phases
      rnd_pixels = 0;
      while (rnd_pixels < 280) begin
         shuffle_idling();
         if ($urandom_range(0, 3) == 0) begin
            write_reg(REG_THRESHOLD,
                      CSR_DATA_W'({5'($urandom_range(0, 31)), pick_threshold()}));
         end
         if ($urandom_range(0, 2) != 0) begin
            write_reg(REG_WIDTH, pick_size());
         end
         if ($urandom_range(0, 2) != 0) begin
            write_reg(REG_HEIGHT, pick_size());
         end
         if ($urandom_range(0, 9) == 0) begin
            write_reg(REG_SPARE, CSR_DATA_W'($urandom_range(0, 8191)));
         end
         area   = fit_size(width_reg, MAX_WIDTH) * fit_size(height_reg, MAX_HEIGHT);
         frames = $urandom_range(1, (area > 40) ? 1 : 3);
         extra  = 0;
         if (area > 1 && $urandom_range(0, 4) == 0) begin
            extra = $urandom_range(1, area - 1);
         end
         push_texture(frames * area + extra);
         rnd_pixels += frames * area + extra;
         settle();
      end

      $display("covered %0d pixels, %0d frame results, %0d register writes", pixels_accepted,
               results_seen, reg_writes);
      $display("sizes 0 to 8191 written, thresholds 0 to 255, a long receiver hold; "
               , "%0d stalled pixel beats", input_stalls);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", errors);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### files.f
hdl/bac_pkg.sv
hdl/bac_if.sv
hdl/bac_ram.sv
hdl/bac_scan.sv
hdl/blocking_artifact_counter_core.sv
tb/sv/tb_top.sv
